// ===== src/circular_fifo_with_key_search_core_assert.svh =====
// Assertion macros for the circular FIFO with key search.
// Used by the top level; needs signals named clk and rst_n in scope.
`ifndef CIRCULAR_FIFO_WITH_KEY_SEARCH_CORE_ASSERT_SVH
`define CIRCULAR_FIFO_WITH_KEY_SEARCH_CORE_ASSERT_SVH

// A condition that must hold at every clock edge out of reset.
`define CFKS_ASSERT(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition that must hold whenever a trigger holds at the same edge.
`define CFKS_ASSERT_IMPL(label, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

`endif

// ===== src/cfks_pkg.sv =====
// Package for the circular FIFO with key search.
// Sizes, operation and status codes, and the types used by the cell and the top level.
package cfks_pkg;

    localparam int CAPACITY   = 15;
    localparam int DATA_WIDTH = 32;
    localparam int SLOT_COUNT = CAPACITY + 1;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int COUNT_W    = $clog2(CAPACITY + 1);

    localparam int IN_DATA_W   = 32;
    localparam int IN_USER_W   = 8;
    localparam int OUT_DATA_W  = 48;
    localparam int OUT_USER_W  = 8;

    localparam logic [1:0] KIND_PUSH = 2'd0;
    localparam logic [1:0] KIND_POP  = 2'd1;
    localparam logic [1:0] KIND_FIND = 2'd2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_REFUSED  = 2'd1;
    localparam logic [1:0] STATUS_NOTFOUND = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_SEARCH = 2'b10
    } state_t;

    typedef struct packed {
        logic               active;
        logic [COUNT_W-1:0] remain;
    } token_t;

    typedef struct packed {
        logic active;
        logic hit;
        logic miss;
    } cell_evt_t;

endpackage

// ===== src/cfks_cell.sv =====
// One storage slot of the FIFO ring together with its stage of the search chain.
// Depends on cfks_pkg.
module cfks_cell (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [cfks_pkg::DATA_WIDTH-1:0] wr_data,
    input  logic [cfks_pkg::DATA_WIDTH-1:0] key,
    input  logic                           inject,
    input  logic [cfks_pkg::COUNT_W-1:0]   inject_count,
    input  cfks_pkg::token_t               tok_in,
    output cfks_pkg::token_t               tok_out,
    output cfks_pkg::cell_evt_t            evt,
    output logic [cfks_pkg::DATA_WIDTH-1:0] data
);
    import cfks_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    token_t                tok_reg;
    token_t                tok_next;
    logic                  match;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_reg <= wr_data;
        end
    end

    always_comb
    begin
        if (inject)
        begin
            tok_next.active = 1'b1;
            tok_next.remain = inject_count;
        end
        else
        begin
            tok_next = tok_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    assign match = (tok_reg.remain != '0) && (data_reg == key);

    always_comb
    begin
        evt.active = tok_reg.active;
        evt.hit    = tok_reg.active && match;
        evt.miss   = tok_reg.active && (tok_reg.remain == '0);
        if (tok_reg.active && (tok_reg.remain != '0) && !match)
        begin
            tok_out.active = 1'b1;
            tok_out.remain = tok_reg.remain - 1'b1;
        end
        else
        begin
            tok_out = '0;
        end
    end

    assign data = data_reg;

endmodule

// ===== src/circular_fifo_with_key_search_core.sv =====
// Top level of the circular FIFO with key search: pointers, control and the ring of cells.
// Depends on cfks_pkg, cfks_cell and circular_fifo_with_key_search_core_assert.svh.
//
//  Channel | Direction | Ports                           | Contents
//  --------+-----------+---------------------------------+---------------------------------
//  s_*     | in        | s_tvalid s_tready s_tdata s_tuser | operation kind and value or key
//  m_*     | out       | m_tvalid m_tready m_tdata m_tuser | status, head word, slot, counts
//
// For push, pop and unknown kinds the result is registered at the accepting edge.
// A find walks a token around the ring from the head, one cell per cycle; a match answers
// with the slot of the matching entry, and a miss answers once the token has passed the
// last entry; on an empty FIFO the result of a find is registered at the accepting edge.
// No word is accepted during a find or while a result waits and the output is not taken.
// Reset clears the pointers, the count, the search tokens and the output valid flag.
module circular_fifo_with_key_search_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cfks_pkg::IN_DATA_W-1:0]  s_tdata,  // [31:0] value
    input  logic [cfks_pkg::IN_USER_W-1:0]  s_tuser,  // [1:0] kind
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] front_value, [32] front_valid, [36:33] found_slot, [40:37] item_count,
    // [41] is_full, [42] is_empty
    output logic [cfks_pkg::OUT_DATA_W-1:0] m_tdata,
    output logic [cfks_pkg::OUT_USER_W-1:0] m_tuser   // [1:0] status
);
    import cfks_pkg::*;

    `include "circular_fifo_with_key_search_core_assert.svh"

    state_t                 state_reg, state_next;
    logic [SLOT_W-1:0]      head_reg, head_next;
    logic [SLOT_W-1:0]      tail_reg, tail_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [DATA_WIDTH-1:0]  key_reg, key_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0]  m_tdata_reg, m_tdata_next;
    logic [OUT_USER_W-1:0]  m_tuser_reg, m_tuser_next;

    logic                   accept;
    logic [1:0]             kind;
    logic [DATA_WIDTH-1:0]  in_value;
    logic                   start;
    logic [DATA_WIDTH-1:0]  front_data;
    logic                   front_ok;
    logic                   any_hit, any_miss;
    logic [SLOT_W-1:0]      hit_slot;
    logic [1:0]             res_status;
    logic [SLOT_W-1:0]      res_slot;
    logic                   res_load;

    logic [DATA_WIDTH-1:0]  cell_data [SLOT_COUNT];
    token_t                 cell_tok  [SLOT_COUNT];
    cell_evt_t              cell_evt  [SLOT_COUNT];
    logic [SLOT_COUNT-1:0]  hit_vec, miss_vec, active_vec;

    assign kind     = s_tuser[1:0];
    assign in_value = DATA_WIDTH'(s_tdata);
    assign s_tready = (state_reg == ST_IDLE) && (!m_tvalid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign start    = accept && (kind == KIND_FIND) && (count_reg != '0);

    function automatic logic [SLOT_W-1:0] wrap_next(input logic [SLOT_W-1:0] pos);
        return (pos == SLOT_W'(SLOT_COUNT - 1)) ? '0 : pos + 1'b1;
    endfunction

    for (genvar i = 0; i < SLOT_COUNT; i++)
    begin : g_cell
        cfks_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .wr_en        (accept && (kind == KIND_PUSH) && (count_reg != COUNT_W'(CAPACITY))
                           && (tail_reg == SLOT_W'(i))),
            .wr_data      (in_value),
            .key          (key_reg),
            .inject       (start && (head_reg == SLOT_W'(i))),
            .inject_count (count_reg),
            .tok_in       (cell_tok[(i + SLOT_COUNT - 1) % SLOT_COUNT]),
            .tok_out      (cell_tok[i]),
            .evt          (cell_evt[i]),
            .data         (cell_data[i])
        );
        assign hit_vec[i]    = cell_evt[i].hit;
        assign miss_vec[i]   = cell_evt[i].miss;
        assign active_vec[i] = cell_evt[i].active;
    end

    assign any_hit  = |hit_vec;
    assign any_miss = |miss_vec;

    always_comb
    begin
        hit_slot = '0;
        for (int i = 0; i < SLOT_COUNT; i++)
        begin
            if (hit_vec[i])
            begin
                hit_slot = hit_slot | SLOT_W'(i);
            end
        end
    end

    assign front_ok   = (count_reg != '0);
    assign front_data = front_ok ? cell_data[head_reg] : '0;

    always_comb
    begin
        state_next = state_reg;
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        key_next   = key_reg;
        res_load   = 1'b0;
        res_status = STATUS_REFUSED;
        res_slot   = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_load = 1'b1;
                    unique case (kind)
                        KIND_PUSH:
                        begin
                            if (count_reg != COUNT_W'(CAPACITY))
                            begin
                                res_status = STATUS_OK;
                                tail_next  = wrap_next(tail_reg);
                                count_next = count_reg + 1'b1;
                            end
                        end
                        KIND_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                res_status = STATUS_OK;
                                head_next  = wrap_next(head_reg);
                                count_next = count_reg - 1'b1;
                            end
                        end
                        KIND_FIND:
                        begin
                            res_status = STATUS_NOTFOUND;
                            if (count_reg != '0)
                            begin
                                res_load   = 1'b0;
                                key_next   = in_value;
                                state_next = ST_SEARCH;
                            end
                        end
                        default:
                        begin
                            res_status = STATUS_REFUSED;
                        end
                    endcase
                end
            end
            ST_SEARCH:
            begin
                if (any_hit || any_miss)
                begin
                    res_load   = 1'b1;
                    res_status = any_hit ? STATUS_OK : STATUS_NOTFOUND;
                    res_slot   = any_hit ? hit_slot : '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tuser_next  = OUT_USER_W'(res_status);
            m_tdata_next  = OUT_DATA_W'({
                (count_next == '0),
                (count_next == COUNT_W'(CAPACITY)),
                4'(count_next),
                4'(res_slot),
                front_ok,
                32'(front_data)
            });
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            head_reg     <= '0;
            tail_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            tail_reg     <= tail_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg     <= key_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    `CFKS_ASSERT(a_count_bound, count_reg <= COUNT_W'(CAPACITY), "entry count above capacity")
    `CFKS_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one cell reports a match")
    `CFKS_ASSERT_IMPL(a_search_token, state_reg == ST_SEARCH, $onehot(active_vec),
                      "search without exactly one token")
    `CFKS_ASSERT_IMPL(a_idle_no_token, state_reg == ST_IDLE, active_vec == '0,
                      "token live while idle")
    `CFKS_ASSERT_IMPL(a_search_blocks, state_reg == ST_SEARCH, !s_tready,
                      "input ready during a search")

endmodule
